// ===== rtl/bus_voltage_running_median_core_assert.svh =====
// Assertion macros used by the running median RTL.
`ifndef BUS_VOLTAGE_RUNNING_MEDIAN_CORE_ASSERT_SVH
`define BUS_VOLTAGE_RUNNING_MEDIAN_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BVRM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BVRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bvrm_pkg.sv =====
`timescale 1ns / 1ps

package bvrm_pkg;

    localparam int BUS_W    = 16;
    localparam int SHUNT_W  = 16;
    localparam int CODE_W   = 13;
    localparam int CODE_LSB = 3;
    localparam int MED_W    = 14;
    localparam int FILL_W   = 4;

    typedef logic [CODE_W-1:0]         t_code;
    typedef logic [MED_W-1:0]          t_median;
    typedef logic signed [SHUNT_W-1:0] t_shunt;

endpackage

// ===== rtl/bvrm_if.sv =====
`timescale 1ns / 1ps

interface bvrm_in_if
    import bvrm_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [BUS_W-1:0]   bus_word;
    logic [SHUNT_W-1:0] shunt_word;

    modport source (output valid, output bus_word, output shunt_word, input ready);
    modport sink   (input valid, input bus_word, input shunt_word, output ready);
endinterface

interface bvrm_out_if
    import bvrm_pkg::*;
;
    logic              valid;
    logic              ready;
    t_median           median_voltage;
    t_shunt            shunt_value;
    logic [FILL_W-1:0] window_fill;

    modport source (output valid, output median_voltage, output shunt_value,
                    output window_fill, input ready);
    modport sink   (input valid, input median_voltage, input shunt_value,
                    input window_fill, output ready);
endinterface

// ===== rtl/bus_voltage_running_median_core.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Beat contents
// i_in     in   bus_word (16b raw bus register), shunt_word (16b raw shunt register)
// o_out    out  median_voltage (14b, 2 mV), shunt_value (16b signed), window_fill (4b)
//
// A beat is held in a sorted copy of the window. Each beat runs one merge pass over it,
// one stored code per cycle through a single compare unit and a read and a write port.
// The result beat is registered when the merge pass has read every kept code. After the
// result beat is taken the block returns to idle before it takes the next input beat.
// The input is not ready from acceptance until the result beat is taken; a stalled output
// simply holds the block. Reset is synchronous and active low; it empties the window.

`include "bus_voltage_running_median_core_assert.svh"

module bus_voltage_running_median_core
    import bvrm_pkg::*;
#(
    parameter int WINDOW_LEN = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bvrm_in_if.sink     i_in,
    bvrm_out_if.source  o_out
);

    localparam int CW     = $clog2(WINDOW_LEN + 1);
    localparam int AW     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int SDEPTH = 2 * (2 ** AW);
    localparam logic [CW-1:0] FULL      = CW'(WINDOW_LEN);
    localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_LEN - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MERGE,
        S_OUT
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_fill, n_fill;
    logic [AW-1:0] r_slot, n_slot;
    logic          r_bank, n_bank;
    logic [CW-1:0] r_r, n_r;
    logic [CW-1:0] r_w, n_w;
    logic          r_inserted, n_inserted;
    logic          r_del_pend, n_del_pend;
    logic [CW-1:0] r_lo_idx, n_lo_idx;
    logic [CW-1:0] r_hi_idx, n_hi_idx;
    t_code         r_code, n_code;
    t_shunt        r_shunt, n_shunt;
    t_code         r_lo_val, n_lo_val;
    t_code         r_hi_val, n_hi_val;
    t_median       r_median, n_median;
    logic [CW-1:0] r_fill_out, n_fill_out;

    t_code         r_hist_mem [WINDOW_LEN];
    t_code         r_hist_q;
    t_code         r_sort_mem [SDEPTH];
    t_code         r_sort_q;

    logic          accept;
    t_code         in_code;
    logic          have;
    logic          skip;
    logic          take_new;
    logic          wr_en;
    t_code         wr_val;
    logic [CW-1:0] new_count;
    logic [AW-1:0] rd_idx;
    logic [CW+FILL_W-1:0] fill_ext;

    assign accept    = i_in.valid && (r_state == S_IDLE);
    assign in_code   = i_in.bus_word[BUS_W-1:CODE_LSB];
    assign have      = r_r < r_fill;
    assign skip      = have && r_del_pend && (r_sort_q == r_hist_q);
    assign take_new  = !r_inserted && (!have || (r_code <= r_sort_q));
    assign new_count = (r_fill == FULL) ? r_fill : r_fill + 1'b1;

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_slot     = r_slot;
        n_bank     = r_bank;
        n_r        = r_r;
        n_w        = r_w;
        n_inserted = r_inserted;
        n_del_pend = r_del_pend;
        n_lo_idx   = r_lo_idx;
        n_hi_idx   = r_hi_idx;
        n_code     = r_code;
        n_shunt    = r_shunt;
        n_lo_val   = r_lo_val;
        n_hi_val   = r_hi_val;
        n_median   = r_median;
        n_fill_out = r_fill_out;
        wr_en      = 1'b0;
        wr_val     = r_code;
        case (r_state)
            S_IDLE: begin
                n_r = '0;
                if (accept) begin
                    n_code     = in_code;
                    n_shunt    = t_shunt'(i_in.shunt_word);
                    n_w        = '0;
                    n_inserted = 1'b0;
                    n_del_pend = (r_fill == FULL);
                    n_slot     = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
                    n_hi_idx   = new_count >> 1;
                    n_lo_idx   = new_count[0] ? (new_count >> 1) : (new_count >> 1) - 1'b1;
                    n_state    = S_MERGE;
                end
            end
            S_MERGE: begin
                if (skip) begin
                    n_r        = r_r + 1'b1;
                    n_del_pend = 1'b0;
                end else if (take_new) begin
                    wr_en      = 1'b1;
                    wr_val     = r_code;
                    n_inserted = 1'b1;
                    n_w        = r_w + 1'b1;
                end else if (have) begin
                    wr_en  = 1'b1;
                    wr_val = r_sort_q;
                    n_w    = r_w + 1'b1;
                    n_r    = r_r + 1'b1;
                end
                if (wr_en && (r_w == r_lo_idx)) begin
                    n_lo_val = wr_val;
                end
                if (wr_en && (r_w == r_hi_idx)) begin
                    n_hi_val = wr_val;
                end
                if (!have) begin
                    n_fill     = wr_en ? r_w + 1'b1 : r_w;
                    n_fill_out = n_fill;
                    n_bank     = ~r_bank;
                    n_median   = {1'b0, n_lo_val} + {1'b0, n_hi_val};
                    n_state    = S_OUT;
                end
            end
            S_OUT: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fill     <= '0;
            r_slot     <= '0;
            r_bank     <= 1'b0;
            r_r        <= '0;
            r_w        <= '0;
            r_inserted <= 1'b0;
            r_del_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_slot     <= n_slot;
            r_bank     <= n_bank;
            r_r        <= n_r;
            r_w        <= n_w;
            r_inserted <= n_inserted;
            r_del_pend <= n_del_pend;
            r_lo_idx   <= n_lo_idx;
            r_hi_idx   <= n_hi_idx;
            r_code     <= n_code;
            r_shunt    <= n_shunt;
            r_lo_val   <= n_lo_val;
            r_hi_val   <= n_hi_val;
            r_median   <= n_median;
            r_fill_out <= n_fill_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hist_q           <= r_hist_mem[r_slot];
            r_hist_mem[r_slot] <= in_code;
        end
    end

    assign rd_idx = (n_r < FULL) ? n_r[AW-1:0] : '0;

    always_ff @(posedge i_clk) begin
        r_sort_q <= r_sort_mem[{r_bank, rd_idx}];
        if (wr_en) begin
            r_sort_mem[{~r_bank, r_w[AW-1:0]}] <= wr_val;
        end
    end

    assign fill_ext             = {{FILL_W{1'b0}}, r_fill_out};
    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = (r_state == S_OUT);
    assign o_out.median_voltage = r_median;
    assign o_out.shunt_value    = r_shunt;
    assign o_out.window_fill    = fill_ext[FILL_W-1:0];

    `BVRM_ASSERT_NOW(a_fill_bounded, i_clk, i_rst_n, 1'b1, r_fill <= FULL,
        "Window fill exceeds the window length.")
    `BVRM_ASSERT_NOW(a_write_behind_read, i_clk, i_rst_n, r_state == S_MERGE,
        int'(r_w) <= int'(r_r) + 1, "Merge write pointer overtook the read pointer.")
    `BVRM_ASSERT_NOW(a_no_ready_with_result, i_clk, i_rst_n, o_out.valid,
        !i_in.ready, "Input ready while a result beat is pending.")
    `BVRM_ASSERT_NEXT(a_accept_starts_merge, i_clk, i_rst_n, i_in.valid && i_in.ready,
        r_state == S_MERGE, "Accepted beat did not start a merge pass.")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import bvrm_pkg::*;

    localparam int WINDOW     = 15;
    localparam int DIRECTED_N = 22;
    localparam int RANDOM_N   = 1200;
    localparam int EXP_DEPTH  = 64;

    typedef struct packed {
        t_median           median_voltage;
        t_shunt            shunt_value;
        logic [FILL_W-1:0] window_fill;
    } t_voltage_beat;

    typedef struct packed {
        logic [BUS_W-1:0]   bus_word;
        logic [SHUNT_W-1:0] shunt_word;
        logic               typed;
        t_voltage_beat      beat;
    } t_stim_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bvrm_in_if  in_if();
    bvrm_out_if out_if();

    bus_voltage_running_median_core #(
        .WINDOW_LEN(WINDOW)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    always #4 i_clk = ~i_clk;

    t_voltage_beat expected_beats [EXP_DEPTH];
    int            exp_head = 0;
    int            exp_tail = 0;
    int            mismatch_count = 0;
    bit            quiet = 1'b0;

    t_code code_history [WINDOW];
    int    codes_held = 0;
    int    next_slot  = 0;

    // Early rows have their results written out; the rest follow the window predictor.
    t_stim_row directed_rows [DIRECTED_N] = '{
        '{16'hFFFF, 16'h8000, 1'b1, '{14'd16382, -16'sd32768, 4'd1}},
        '{16'h0007, 16'h7FFF, 1'b1, '{14'd8191, 16'sd32767, 4'd2}},
        '{16'hFFF8, 16'hFFFF, 1'b1, '{14'd16382, -16'sd1, 4'd3}},
        '{16'h0000, 16'h0000, 1'b1, '{14'd8191, 16'sd0, 4'd4}},
        '{16'h0008, 16'h0001, 1'b1, '{14'd2, 16'sd1, 4'd5}},
        '{16'h5555, 16'h0002, 1'b0, '0},
        '{16'hAAAA, 16'hFFFE, 1'b0, '0},
        '{16'h1230, 16'h4000, 1'b0, '0},
        '{16'h1237, 16'hC000, 1'b0, '0},
        '{16'hFFFF, 16'h5555, 1'b0, '0},
        '{16'h0000, 16'hAAAA, 1'b0, '0},
        '{16'h8000, 16'h8001, 1'b0, '0},
        '{16'h7FFF, 16'h7FFE, 1'b0, '0},
        '{16'h4000, 16'h0100, 1'b0, '0},
        '{16'h4008, 16'hFF00, 1'b0, '0},
        '{16'h3FF8, 16'h1234, 1'b0, '0},
        '{16'h4000, 16'hEDCB, 1'b0, '0},
        '{16'hC000, 16'h0F0F, 1'b0, '0},
        '{16'h0010, 16'hF0F0, 1'b0, '0},
        '{16'hFFF0, 16'h3333, 1'b0, '0},
        '{16'h2468, 16'hCCCC, 1'b0, '0},
        '{16'h8004, 16'h0000, 1'b0, '0}
    };

    function automatic t_voltage_beat window_median(input logic [BUS_W-1:0] bus_word,
                                                    input logic [SHUNT_W-1:0] shunt_word);
        t_code         ranked [WINDOW];
        t_code         key;
        t_voltage_beat beat;
        int            j;
        int            mid;
        code_history[next_slot] = bus_word[BUS_W-1:CODE_LSB];
        next_slot = (next_slot + 1) % WINDOW;
        if (codes_held < WINDOW) begin
            codes_held++;
        end
        for (int i = 0; i < codes_held; i++) begin
            ranked[i] = code_history[i];
        end
        for (int i = 1; i < codes_held; i++) begin
            key = ranked[i];
            j   = i;
            while (j > 0 && ranked[j-1] > key) begin
                ranked[j] = ranked[j-1];
                j--;
            end
            ranked[j] = key;
        end
        mid = codes_held / 2;
        if (codes_held % 2 != 0) begin
            beat.median_voltage = t_median'(ranked[mid]) + t_median'(ranked[mid]);
        end else begin
            beat.median_voltage = t_median'(ranked[mid-1]) + t_median'(ranked[mid]);
        end
        beat.shunt_value = t_shunt'(shunt_word);
        beat.window_fill = FILL_W'(codes_held);
        return beat;
    endfunction

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic send_beat(input logic [BUS_W-1:0] bus_word,
                             input logic [SHUNT_W-1:0] shunt_word,
                             input logic typed, input t_voltage_beat typed_beat);
        t_voltage_beat predicted;
        int            gap;
        gap = idle_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.bus_word   <= bus_word;
        in_if.shunt_word <= shunt_word;
        do @(posedge i_clk); while (!in_if.ready);
        predicted = window_median(bus_word, shunt_word);
        expected_beats[exp_tail % EXP_DEPTH] = typed ? typed_beat : predicted;
        exp_tail++;
    endtask

    initial begin : result_backpressure
        int stall;
        int r;
        stall = 0;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (quiet) begin
                out_if.ready <= 1'b1;
            end else if (stall > 0) begin
                out_if.ready <= 1'b0;
                stall--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    stall = $urandom_range(15, 60);
                    out_if.ready <= 1'b0;
                end else begin
                    out_if.ready <= (r < 75);
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_voltage_beat want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (exp_tail == exp_head) begin
                $error("result beat with no expectation pending");
                mismatch_count++;
            end else begin
                want = expected_beats[exp_head % EXP_DEPTH];
                exp_head++;
                if (out_if.median_voltage !== want.median_voltage) begin
                    $error("median_voltage: expected %0d, got %0d",
                           want.median_voltage, out_if.median_voltage);
                    mismatch_count++;
                end
                if (out_if.shunt_value !== want.shunt_value) begin
                    $error("shunt_value: expected %0d, got %0d",
                           want.shunt_value, out_if.shunt_value);
                    mismatch_count++;
                end
                if (out_if.window_fill !== want.window_fill) begin
                    $error("window_fill: expected %0d, got %0d",
                           want.window_fill, out_if.window_fill);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        int                 level;
        int                 code;
        int                 r;
        logic [BUS_W-1:0]   bus_word;
        logic [SHUNT_W-1:0] shunt_word;
        in_if.valid      = 1'b0;
        in_if.bus_word   = '0;
        in_if.shunt_word = '0;
        level            = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < DIRECTED_N; n++) begin
            send_beat(directed_rows[n].bus_word, directed_rows[n].shunt_word,
                      directed_rows[n].typed, directed_rows[n].beat);
        end

        // Mostly a steady level with jitter, so the window holds close and equal codes.
        for (int n = 0; n < RANDOM_N; n++) begin
            if (n % 150 == 0) begin
                quiet = ($urandom_range(0, 3) == 0);
            end
            if (n % 40 == 0) begin
                level = $urandom_range(0, 8191);
            end
            r = $urandom_range(0, 99);
            if (r < 60) begin
                code = level + int'($urandom_range(0, 16)) - 8;
                if (code < 0) begin
                    code = 0;
                end else if (code > 8191) begin
                    code = 8191;
                end
            end else if (r < 75) begin
                code = $urandom_range(0, 8191);
            end else if (r < 90) begin
                code = -1;
            end else begin
                code = $urandom_range(0, 1) ? 8191 : 0;
            end
            if (code < 0) begin
                bus_word = BUS_W'($urandom());
            end else begin
                bus_word = {t_code'(code), 3'($urandom_range(0, 7))};
            end
            r = $urandom_range(0, 99);
            if (r < 85) begin
                shunt_word = SHUNT_W'($urandom());
            end else if (r < 89) begin
                shunt_word = 16'h8000;
            end else if (r < 93) begin
                shunt_word = 16'h7FFF;
            end else if (r < 97) begin
                shunt_word = 16'hFFFF;
            end else begin
                shunt_word = 16'h0000;
            end
            send_beat(bus_word, shunt_word, 1'b0, '0);
        end

        in_if.valid <= 1'b0;
        while (exp_tail != exp_head) @(posedge i_clk);
        repeat (WINDOW + 4) @(posedge i_clk);
        if (mismatch_count == 0 && exp_tail == exp_head) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin : watchdog
        #6_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
